// ----- rtl/mse_pkg.sv -----
// Package for the MIPS-subset executor: command and error codes, controller/datapath structs.
// No dependencies.
package mse_pkg;

	typedef enum logic [3:0] {
		CMD_ADD   = 4'd0,
		CMD_SUB   = 4'd1,
		CMD_MUL   = 4'd2,
		CMD_SLT   = 4'd3,
		CMD_ADDI  = 4'd4,
		CMD_LI    = 4'd5,
		CMD_LW    = 4'd6,
		CMD_SW    = 4'd7,
		CMD_BEQ   = 4'd8,
		CMD_BNE   = 4'd9,
		CMD_J     = 4'd10,
		CMD_LABEL = 4'd11
	} cmd_t;

	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_ZERO_WR = 3'd1;
	localparam logic [2:0] ERR_ALIGN   = 3'd2;
	localparam logic [2:0] ERR_RANGE   = 3'd3;
	localparam logic [2:0] ERR_LABEL   = 3'd4;

	localparam logic [4:0] SP_REG = 5'd29;

	// Controller to datapath commands.
	typedef struct packed {
		logic exec;     // latch request, evaluate, store to or read memory
		logic finish;   // commit and form the result
	} dp_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic clearing; // memory clear pass running
	} dp_status_t;

endpackage

// ----- rtl/mips_subset_execute_top.sv -----
// Top level of the MIPS-subset executor: stream ports, config port.
// Depends on mse_pkg, mse_ctrl, mse_datapath.
//
// Executes one decoded instruction per request and returns one result per
// request. Each request has two steps: one to read registers, evaluate, store and
// issue the synchronous data-memory read, one to commit state and load the
// output register; a new request is taken only once the last has finished.
// A result waiting in the output register holds off the next request until it
// is taken. After reset a clearing pass zeroes the data memory, one word per
// cycle, over MEM_WORDS rounded up to a power of two words, during which no
// request is taken; stack pointer writes are always accepted and belong only
// where no request is in flight. Errors halt the block; every later request
// answers error 4.
module mips_subset_execute_top import mse_pkg::*; #(
	parameter int MEM_WORDS     = 262144,
	parameter int PROGRAM_LINES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// command[3:0], dest_reg[8:4], src_a[13:9], src_b[18:14], immediate[50:19],
	// target_line[60:51], target_known[61], zero pad[63:62]
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// next_pc[10:0], error_code[13:11], reg_written[14], write_reg[19:15],
	// write_value[51:20], executed_count[83:52], zero pad[87:84]
	output logic [87:0] m_tdata
);
	dp_cmd_t    cmd;
	dp_status_t status;
	logic [10:0] next_pc;
	logic [2:0]  error_code;
	logic        reg_written;
	logic [4:0]  write_reg;
	logic [31:0] write_value, executed_count;

	assign cfg_ready = 1'b1;

	mse_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.status, .cmd
	);

	mse_datapath #(.MEM_WORDS(MEM_WORDS), .PROGRAM_LINES(PROGRAM_LINES)) u_dp (
		.clk, .arst_n, .cmd, .status,
		.cfg_we(cfg_valid), .cfg_data,
		.command(s_tdata[3:0]), .dest_reg(s_tdata[8:4]), .src_a(s_tdata[13:9]),
		.src_b(s_tdata[18:14]), .immediate(s_tdata[50:19]),
		.target_line(s_tdata[60:51]), .target_known(s_tdata[61]),
		.next_pc, .error_code, .reg_written, .write_reg, .write_value, .executed_count
	);

	assign m_tdata = {4'd0, executed_count, write_value, write_reg, reg_written,
		error_code, next_pc};
endmodule

// ----- rtl/mse_ctrl.sv -----
// Controller for the MIPS-subset executor: request/result handshake sequencing.
// Depends on mse_pkg.
module mse_ctrl import mse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);
	typedef enum logic [1:0] {ST_IDLE, ST_EXEC} state_t;
	state_t state_q;
	logic   out_valid_q;

	// Output register frees at the finish cycle if taken then.
	assign in_ready  = (state_q == ST_IDLE) && !status.clearing && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign cmd.exec  = in_valid && in_ready;
	assign cmd.finish = (state_q == ST_EXEC) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (out_valid_q && out_ready) out_valid_q <= 1'b0;
					if (cmd.exec) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (cmd.finish) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/mse_datapath.sv -----
// Datapath for the MIPS-subset executor: register file, data memory, PC, ALU.
// Depends on mse_pkg.
module mse_datapath import mse_pkg::*; #(
	parameter int MEM_WORDS     = 262144,
	parameter int PROGRAM_LINES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_status_t  status,
	input  logic        cfg_we,
	input  logic [31:0] cfg_data,
	input  logic [3:0]  command,
	input  logic [4:0]  dest_reg,
	input  logic [4:0]  src_a,
	input  logic [4:0]  src_b,
	input  logic [31:0] immediate,
	input  logic [9:0]  target_line,
	input  logic        target_known,
	output logic [10:0] next_pc,
	output logic [2:0]  error_code,
	output logic        reg_written,
	output logic [4:0]  write_reg,
	output logic [31:0] write_value,
	output logic [31:0] executed_count
);
	localparam int AW = $clog2(MEM_WORDS);
	localparam int PW = $clog2(PROGRAM_LINES + 1);
	localparam logic [PW-1:0] PC_MAX = PW'(PROGRAM_LINES);

	logic [31:0]   regs_q [32];
	logic [31:0]   mem [MEM_WORDS];
	logic [AW:0]   clr_q;
	logic [PW-1:0] pc_q;
	logic [31:0]   count_q;
	logic          halted_q;

	// Stage 1 registers
	logic [31:0]   val_s1, mem_rd_s1;
	logic          is_lw_s1, wr_s1, lbl_s1, none_s1;
	logic [2:0]    err_s1;
	logic [4:0]    dst_s1;
	logic [PW-1:0] next_s1;

	assign status.clearing = !clr_q[AW];

	logic [31:0] a, b, d, addr, val;
	logic [31:0] prod;
	logic [2:0]  err;
	logic        wr, take, eq, slt_lt, sw_en, lbl, lw;
	logic [PW-1:0] seq, jump, nxt;
	logic [31:0] seq_w, jump_w;

	always_comb begin
		a = (src_a == 5'd0) ? 32'd0 : regs_q[src_a];
		b = (src_b == 5'd0) ? 32'd0 : regs_q[src_b];
		d = (dest_reg == 5'd0) ? 32'd0 : regs_q[dest_reg];
		addr = a + immediate;
		prod = a * b;
		slt_lt = $signed(a) < $signed(b);
		eq = (d == a);
		seq_w  = 32'(pc_q) + 32'd1;
		jump_w = 32'(target_line) + 32'd1;
		seq  = (seq_w > 32'(PROGRAM_LINES)) ? PC_MAX : seq_w[PW-1:0];
		jump = (jump_w > 32'(PROGRAM_LINES)) ? PC_MAX : jump_w[PW-1:0];
		val = 32'd0; wr = 1'b0; err = ERR_NONE; nxt = seq; sw_en = 1'b0;
		lbl = 1'b0; lw = 1'b0; take = 1'b0;
		case (command)
			CMD_ADD:  begin val = a + b; wr = 1'b1; end
			CMD_SUB:  begin val = a - b; wr = 1'b1; end
			CMD_MUL:  begin val = prod; wr = 1'b1; end
			CMD_SLT:  begin val = {31'd0, slt_lt}; wr = 1'b1; end
			CMD_ADDI: begin val = a + immediate; wr = 1'b1; end
			CMD_LI:   begin val = immediate; wr = 1'b1; end
			CMD_LW, CMD_SW: begin
				if (addr[1:0] != 2'd0) err = ERR_ALIGN;
				else if (addr[31] || (addr[30:2] >= 29'(MEM_WORDS))) err = ERR_RANGE;
				else if (command == CMD_LW) begin
					wr = 1'b1; lw = 1'b1;
				end else sw_en = 1'b1;
			end
			CMD_BEQ, CMD_BNE: begin
				take = (command == CMD_BEQ) ? eq : !eq;
				if (take) begin
					if (target_known) nxt = jump; else err = ERR_LABEL;
				end
			end
			CMD_J: begin
				if (target_known) nxt = jump; else err = ERR_LABEL;
			end
			default: lbl = 1'b1;
		endcase
		if (wr && dest_reg == 5'd0) begin
			err = ERR_ZERO_WR; wr = 1'b0; lw = 1'b0;
		end
		if (halted_q) begin
			err = ERR_LABEL; wr = 1'b0; lw = 1'b0; sw_en = 1'b0; lbl = 1'b0;
		end
	end

	// Memory: clear pass after reset, store on exec, registered read on exec.
	always_ff @(posedge clk) begin
		if (!clr_q[AW]) mem[clr_q[AW-1:0]] <= 32'd0;
		else if (cmd.exec && sw_en) mem[addr[AW+1:2]] <= d;
		if (cmd.exec) mem_rd_s1 <= mem[addr[AW+1:2]];
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			val_s1   <= val;
			is_lw_s1 <= lw;
			wr_s1    <= wr;
			lbl_s1   <= lbl;
			none_s1  <= halted_q;
			err_s1   <= err;
			dst_s1   <= dest_reg;
			next_s1  <= nxt;
		end
		if (cmd.finish) begin
			next_pc        <= 11'(((err_s1 != ERR_NONE) || none_s1) ? pc_q : next_s1);
			error_code     <= err_s1;
			reg_written    <= wr_s1;
			write_reg      <= wr_s1 ? dst_s1 : 5'd0;
			write_value    <= wr_s1 ? (is_lw_s1 ? mem_rd_s1 : val_s1) : 32'd0;
			executed_count <= (err_s1 == ERR_NONE && !lbl_s1) ? count_q + 1'b1 : count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			pc_q     <= '0;
			count_q  <= '0;
			halted_q <= 1'b0;
			for (int i = 0; i < 32; i++) regs_q[i] <= (i == 29) ? 32'd2147479548 : 32'd0;
		end else begin
			if (!clr_q[AW]) clr_q <= clr_q + 1'b1;
			if (cfg_we) regs_q[SP_REG] <= cfg_data;
			if (cmd.finish && !none_s1) begin
				if (err_s1 != ERR_NONE) halted_q <= 1'b1;
				else begin
					pc_q <= next_s1;
					if (!lbl_s1) count_q <= count_q + 1'b1;
					if (wr_s1) regs_q[dst_s1] <= is_lw_s1 ? mem_rd_s1 : val_s1;
				end
			end
		end
	end
endmodule
